[hw/rtl/modexp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modexp_pkg
// Types and constants shared by the modular exponentiation controller,
// datapath and top level.
// ----------------------------------------------------------------------------
package modexp_pkg;

	localparam int unsigned MOD_W = 31;
	localparam int unsigned OPD_W = 63;
	localparam int unsigned CNT_W = 6;

	localparam logic [MOD_W-1:0] MODULUS_RESET = 31'd1000000007;

	// Last step index of one bit-serial reduction (one step per dividend bit)
	localparam logic [CNT_W-1:0] RED_LAST = 6'd62;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BASE,
		ST_SETUP,
		ST_CHECK,
		ST_MUL,
		ST_UPDATE,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load_base;
		logic take_base;
		logic load_mul;
		logic step;
		logic update;
		logic write_out;
	} dp_cmd_t;

	typedef struct packed {
		logic exp_zero;
		logic mod_small;
		logic out_busy;
	} dp_sts_t;

endpackage

[hw/rtl/modexp_rem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modexp_rem
// Bit-serial remainder unit: reduces a 63-bit dividend modulo a 31-bit
// modulus, one dividend bit per step, most significant bit first.
// ----------------------------------------------------------------------------
module modexp_rem (
	input  logic                               clk,
	input  logic                               load,
	input  logic                               step,
	input  logic [modexp_pkg::OPD_W-1:0]       dividend,
	input  logic [modexp_pkg::MOD_W-1:0]       modulus,
	output logic [modexp_pkg::MOD_W-1:0]       rem
);
	import modexp_pkg::*;

	logic [OPD_W-1:0] div_q;
	logic [MOD_W-1:0] rem_q;
	logic [MOD_W:0]   trial;
	logic [MOD_W:0]   diff;
	logic [MOD_W-1:0] rem_nxt;

	// Remainder stays below the modulus, so the shifted trial fits in 32 bits
	always_comb begin
		trial   = {rem_q, div_q[OPD_W-1]};
		diff    = trial - {1'b0, modulus};
		rem_nxt = (trial >= {1'b0, modulus}) ? diff[MOD_W-1:0] : trial[MOD_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (load) begin
			div_q <= dividend;
			rem_q <= '0;
		end else if (step) begin
			div_q <= {div_q[OPD_W-2:0], 1'b0};
			rem_q <= rem_nxt;
		end
	end

	assign rem = rem_q;

endmodule

[hw/rtl/modexp_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modexp_dp
// Datapath: modulus register, exponent shifter, result and running base,
// two multipliers feeding two remainder units, and the output register.
// ----------------------------------------------------------------------------
module modexp_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [modexp_pkg::MOD_W-1:0]       cfg_wr_data,
	input  logic [modexp_pkg::OPD_W-1:0]       in_base,
	input  logic [modexp_pkg::OPD_W-1:0]       in_exponent,
	input  logic                               m_tready,
	output logic                               m_tvalid,
	output logic [modexp_pkg::MOD_W-1:0]       power,
	input  modexp_pkg::dp_cmd_t                cmd,
	output modexp_pkg::dp_sts_t                sts
);
	import modexp_pkg::*;

	logic [MOD_W-1:0]   modulus_q;
	logic [OPD_W-1:0]   exp_q;
	logic [MOD_W-1:0]   acc_q;
	logic [MOD_W-1:0]   run_q;
	logic [MOD_W-1:0]   power_q;
	logic               out_valid_q;
	logic [2*MOD_W-1:0] prod_a;
	logic [2*MOD_W-1:0] prod_b;
	logic [OPD_W-1:0]   div_a;
	logic [OPD_W-1:0]   div_b;
	logic [MOD_W-1:0]   rem_a;
	logic [MOD_W-1:0]   rem_b;
	logic               mod_small;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= MODULUS_RESET;
		end else if (cfg_wr_en) begin
			modulus_q <= cfg_wr_data;
		end
	end

	assign mod_small = (modulus_q[MOD_W-1:1] == '0);

	// Both products use the old running base, so multiply and square run side by side
	assign prod_a = {{MOD_W{1'b0}}, acc_q} * {{MOD_W{1'b0}}, run_q};
	assign prod_b = {{MOD_W{1'b0}}, run_q} * {{MOD_W{1'b0}}, run_q};
	assign div_a  = {1'b0, prod_a};
	assign div_b  = cmd.load_base ? in_base : {1'b0, prod_b};

	modexp_rem u_rem_a (
		.clk      (clk),
		.load     (cmd.load_mul),
		.step     (cmd.step),
		.dividend (div_a),
		.modulus  (modulus_q),
		.rem      (rem_a)
	);

	modexp_rem u_rem_b (
		.clk      (clk),
		.load     (cmd.load_base | cmd.load_mul),
		.step     (cmd.step),
		.dividend (div_b),
		.modulus  (modulus_q),
		.rem      (rem_b)
	);

	always_ff @(posedge clk) begin
		if (cmd.load_base) begin
			exp_q <= in_exponent;
			acc_q <= {{(MOD_W-1){1'b0}}, 1'b1};
		end else if (cmd.update) begin
			exp_q <= {1'b0, exp_q[OPD_W-1:1]};
			if (exp_q[0]) begin
				acc_q <= rem_a;
			end
		end
		if (cmd.take_base || cmd.update) begin
			run_q <= rem_b;
		end
		if (cmd.write_out) begin
			power_q <= mod_small ? '0 : acc_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.write_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid      = out_valid_q;
	assign power         = power_q;
	assign sts.exp_zero  = (exp_q == '0);
	assign sts.mod_small = mod_small;
	assign sts.out_busy  = out_valid_q & ~m_tready;

endmodule

[hw/rtl/modexp_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modexp_ctrl
// Controller: sequences base reduction, the per-bit multiply and square
// passes and the hand-off to the output register.
// ----------------------------------------------------------------------------
module modexp_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  modexp_pkg::dp_sts_t sts,
	output modexp_pkg::dp_cmd_t cmd
);
	import modexp_pkg::*;

	state_t           state_q;
	state_t           state_nxt;
	logic [CNT_W-1:0] cnt_q;
	logic             cnt_last;

	assign cnt_last = (cnt_q == RED_LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nxt;
			if (cmd.step) begin
				cnt_q <= cnt_last ? '0 : cnt_q + 1'b1;
			end
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_nxt = sts.mod_small ? ST_DONE : ST_BASE;
				end
			end
			ST_BASE: begin
				if (cnt_last) begin
					state_nxt = ST_SETUP;
				end
			end
			ST_SETUP: begin
				state_nxt = ST_CHECK;
			end
			ST_CHECK: begin
				state_nxt = sts.exp_zero ? ST_DONE : ST_MUL;
			end
			ST_MUL: begin
				if (cnt_last) begin
					state_nxt = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				state_nxt = ST_CHECK;
			end
			ST_DONE: begin
				if (!sts.out_busy) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready      = 1'b1;
				cmd.load_base = s_tvalid;
			end
			ST_BASE: begin
				cmd.step = 1'b1;
			end
			ST_SETUP: begin
				cmd.take_base = 1'b1;
			end
			ST_CHECK: begin
				cmd.load_mul = ~sts.exp_zero;
			end
			ST_MUL: begin
				cmd.step = 1'b1;
			end
			ST_UPDATE: begin
				cmd.update = 1'b1;
			end
			ST_DONE: begin
				// hold the result until the output register frees up
				cmd.write_out = ~sts.out_busy;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

[hw/rtl/modular_exponentiation.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_exponentiation
// Computes base ** exponent mod modulus by right-to-left square and multiply.
// ----------------------------------------------------------------------------
// One item at a time. After acceptance the base is reduced and then taken
// over as the running base, then each exponent bit up to the highest set one
// costs a check, a reduction pass and an update, plus a final check and the
// hand-off to the output register.
// The bit-serial remainder units take one product bit per cycle; the
// multiply and the square share each reduction pass in two lanes. A zero
// exponent gives 1; a modulus below 2 gives 0 with no reduction pass.
// A new item is taken while an earlier result still waits on the output.
// The modulus register resets to 1000000007; the user must write it only
// while idle, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
module modular_exponentiation (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_wr_en,
	input  logic [30:0]  cfg_wr_data,   // modulus
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [127:0] s_tdata,       // base [62:0], exponent [125:63], zero pad
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [31:0]  m_tdata        // power [30:0], zero pad
);
	import modexp_pkg::*;

	dp_cmd_t          cmd;
	dp_sts_t          sts;
	logic [MOD_W-1:0] power;

	modexp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	modexp_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_base     (s_tdata[62:0]),
		.in_exponent (s_tdata[125:63]),
		.m_tready    (m_tready),
		.m_tvalid    (m_tvalid),
		.power       (power),
		.cmd         (cmd),
		.sts         (sts)
	);

	assign m_tdata = {1'b0, power};

	a_write_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.write_out |-> !(m_tvalid && !m_tready))
		else $error("result written over a pending output item");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input taken again right after an accepted item");

	a_no_step_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> !s_tready)
		else $error("reduction step while ready for input");

	a_mul_needs_bits: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_mul |-> !sts.exp_zero)
		else $error("multiply pass started with exponent exhausted");

endmodule

[bench/tb_modular_exponentiation.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_modular_exponentiation
// Streams base/exponent pairs into the exponentiation block and checks every
// returned power against an in-bench square-and-multiply predictor. Covers
// directed corner cases (zero exponent, modulus below two, full-width
// operands), then random items over several modulus settings with source
// idling, sink stalls, one long sink hold-off and drains between settings.
// ----------------------------------------------------------------------------
module tb_modular_exponentiation;
	import modexp_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 3000000;
	localparam int unsigned HOLD_CYCLES = 3000;
	localparam logic [OPD_W-1:0] OPD_MAX = '1;
	localparam logic [MOD_W-1:0] MOD_MAX = '1;

	// Expected powers in acceptance order, computed from a private modulus copy
	class power_board;
		logic [MOD_W-1:0] modulus;
		logic [MOD_W-1:0] power_q[$];
		int errors;

		function new();
			modulus = MODULUS_RESET;
			errors = 0;
		endfunction

		function void set_modulus(logic [MOD_W-1:0] m);
			modulus = m;
		endfunction

		// Right-to-left square and multiply; operands stay below 2^31, products below 2^62
		function logic [MOD_W-1:0] power_of(logic [OPD_W-1:0] b, logic [OPD_W-1:0] e);
			logic [63:0] m;
			logic [63:0] acc;
			logic [63:0] run;
			logic [OPD_W-1:0] rest;
			m = {33'd0, modulus};
			if (m < 64'd2)
				return '0;
			acc = 64'd1;
			run = {1'b0, b} % m;
			rest = e;
			while (rest != '0) begin
				if (rest[0])
					acc = (acc * run) % m;
				run = (run * run) % m;
				rest = rest >> 1;
			end
			return acc[MOD_W-1:0];
		endfunction

		function void note_item(logic [OPD_W-1:0] b, logic [OPD_W-1:0] e);
			power_q = {power_q, power_of(b, e)};
		endfunction

		function int pending();
			return power_q.size();
		endfunction

		task report(string msg);
			$display("ERROR @%0t: %s", $time, msg);
			errors++;
		endtask

		task check_power(logic [31:0] word);
			logic [MOD_W-1:0] want;
			if (power_q.size() == 0) begin
				report($sformatf("power 0x%08h with no item outstanding", word));
			end else begin
				want = power_q.pop_front();
				if (word !== {1'b0, want})
					report($sformatf("power 0x%08h, predicted 0x%08h", word, {1'b0, want}));
			end
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [30:0] cfg_wr_data = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [127:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [31:0] m_tdata;

	power_board board;
	int unsigned cycles = 0;
	int unsigned send_idle_pct = 0;
	int unsigned stall_pct = 0;
	logic hold_armed = 1'b0;
	int unsigned hold_count = 0;

	modular_exponentiation u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Sink: one long hold-off once armed, random stalls otherwise
	always @(posedge clk) begin
		if (hold_armed && hold_count < HOLD_CYCLES) begin
			hold_count <= hold_count + 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.check_power(m_tdata);
	end

	function automatic logic [OPD_W-1:0] rand_word();
		logic [63:0] w;
		w = {$urandom, $urandom};
		return w[OPD_W-1:0];
	endfunction

	// Mostly short exponents keep the run short; a few reach full width
	function automatic logic [OPD_W-1:0] rand_exponent();
		int unsigned bits;
		logic [OPD_W-1:0] e;
		bits = ($urandom_range(99) < 85) ? $urandom_range(12) : $urandom_range(63, 13);
		if (bits == 0)
			return '0;
		e = rand_word() & ((63'd1 << bits) - 63'd1);
		e[bits-1] = 1'b1;
		return e;
	endfunction

	function automatic logic [OPD_W-1:0] rand_base();
		case ($urandom_range(3))
			0: return 63'($urandom_range(20));
			1: return {32'd0, board.modulus} * 63'($urandom_range(3));
			default: return rand_word();
		endcase
	endfunction

	function automatic logic [MOD_W-1:0] rand_modulus();
		case ($urandom_range(7))
			0: return 31'($urandom_range(64, 2));
			1: return MOD_MAX - 31'($urandom_range(100));
			2: return 31'd1 << $urandom_range(30, 1);
			3: return 31'($urandom_range(1));
			default: return 31'($urandom_range(MOD_MAX, 2));
		endcase
	endfunction

	task automatic send_item(input logic [OPD_W-1:0] b, input logic [OPD_W-1:0] e);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {2'b00, e, b};
		do
			@(posedge clk);
		while (!s_tready);
		board.note_item(b, e);
	endtask

	// Hold the source until every predicted power has come back
	task automatic drain();
		s_tvalid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
	endtask

	task automatic write_modulus(input logic [MOD_W-1:0] m);
		drain();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= m;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		board.set_modulus(m);
	endtask

	task automatic run_phase(input int items, input int unsigned idle, input int unsigned stall);
		send_idle_pct = idle;
		stall_pct <= stall;
		for (int i = 0; i < items; i++) begin
			if (i % 10 == 0)
				write_modulus(rand_modulus());
			send_item(rand_base(), rand_exponent());
		end
		drain();
	endtask

	initial begin
		board = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset modulus
		send_item('0, '0);
		send_item(OPD_MAX, OPD_MAX);
		send_item(63'd2, 63'd10);
		send_item('0, 63'd5);
		send_item(63'd1000000007, 63'd1);
		send_item(OPD_MAX, '0);

		write_modulus(MOD_MAX);
		send_item(OPD_MAX, OPD_MAX);
		send_item(63'd2147483646, 63'd2);
		send_item(63'h8000_0000, 63'h5555_5555_5555_5555);
		send_item(63'h2AAA_AAAA_AAAA_AAAA, 63'h2AAA_AAAA_AAAA_AAAA);

		write_modulus(31'd2);
		send_item(63'd3, OPD_MAX);
		send_item(63'd2, '0);
		send_item(63'd5, 63'd1);

		// Modulus below two forces zero, even for a zero exponent
		write_modulus(31'd1);
		send_item(63'd7, '0);
		send_item(OPD_MAX, OPD_MAX);
		write_modulus('0);
		send_item(63'd5, 63'd3);
		send_item('0, '0);

		write_modulus(31'h4000_0000);
		send_item(63'd3, 63'h4000_0000_0000_0000);

		run_phase(35, 0, 0);
		run_phase(30, 86, 0);
		run_phase(30, 0, 86);
		run_phase(30, 38, 38);

		// Long sink hold-off: the block fills and must stall its input
		write_modulus(rand_modulus());
		send_idle_pct = 0;
		stall_pct <= 0;
		hold_armed <= 1'b1;
		for (int i = 0; i < 10; i++)
			send_item(rand_base(), rand_word() & 63'h3F);
		drain();

		repeat (200) @(posedge clk);
		if (board.pending() != 0)
			board.report($sformatf("%0d powers never arrived", board.pending()));
		if (board.errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

[modular_exponentiation.f]
hw/rtl/modexp_pkg.sv
hw/rtl/modexp_rem.sv
hw/rtl/modexp_dp.sv
hw/rtl/modexp_ctrl.sv
hw/rtl/modular_exponentiation.sv
bench/tb_modular_exponentiation.sv
